[design/aba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging block allocator package
// Shared constants, request codes and sequencer states of the allocator.
// ----------------------------------------------------------------------------
package aba_pkg;

    localparam int DEF_BLOCK_COUNT     = 256;
    localparam int DEF_RESERVED_BLOCKS = 2;

    localparam int ENTRY_W = 8;
    localparam int AGE_W   = 4;
    localparam int COUNT_W = 9;

    localparam logic [AGE_W-1:0]   BIRTH_AGE = 4'hC;
    localparam logic [AGE_W-1:0]   AGE_MAX   = 4'hF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1FF;

    typedef enum logic [2:0] {
        REQ_ALLOC     = 3'd0,
        REQ_FREE      = 3'd1,
        REQ_LOAD      = 3'd2,
        REQ_READ      = 3'd3,
        REQ_SET_COUNT = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_AGE,
        S_EVICT,
        S_ANCHOR_RD,
        S_ANCHOR_CHK,
        S_READ_WAIT
    } state_t;

endpackage

[design/aba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port per cycle, with registered read data.
// ----------------------------------------------------------------------------
module aba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/aging_block_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging block allocator
// Block table with file type and age per entry, a used-block count, and a
// sequencer that serves allocate, free, load, read and set-count requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// transaction follows, shown for a single cycle with done high, and the
// receiver must take it then. Free, load entry, set used count and unused
// request codes finish in the cycle they are taken (done on the next cycle);
// read entry of a block inside the table keeps busy high in the read wait
// state while the table read completes, and a read outside the table
// finishes in the cycle it is taken. Allocate walks the table through one
// RAM read port and one write port, one entry per cycle: a scan for a free
// entry, up to two aging passes, and the eviction write and the anchor
// check; done follows in the first cycle after busy falls. After reset the
// block runs a clearing pass that zeroes the table, and busy stays high
// until it ends.
// ----------------------------------------------------------------------------
module aging_block_allocator_unit #(
    parameter int BLOCK_COUNT     = aba_pkg::DEF_BLOCK_COUNT,
    parameter int RESERVED_BLOCKS = aba_pkg::DEF_RESERVED_BLOCKS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] req_type,
    input  logic [7:0] target_block,
    input  logic [3:0] file_kind,
    input  logic [7:0] entry_data,
    input  logic [8:0] count_data,
    output logic       done,
    output logic [7:0] granted_block,
    output logic       evicted,
    output logic       status,
    output logic [7:0] entry_out,
    output logic [8:0] used_out
);

    // Address width of the table, and a counter width that can also hold
    // BLOCK_COUNT and RESERVED_BLOCKS themselves.
    localparam int AW = $clog2(BLOCK_COUNT);
    localparam int CW = $clog2(BLOCK_COUNT + RESERVED_BLOCKS + 2);
    // Width for the relative-time compare: used*16 against (16-anchor)*blocks.
    localparam int TW = 14 + $clog2(BLOCK_COUNT + 1);

    localparam logic [CW-1:0] B_C = CW'(BLOCK_COUNT);
    localparam logic [CW-1:0] R_C = CW'(RESERVED_BLOCKS);

    aba_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pidx_reg, pidx_next;
    logic            post_reg, post_next;
    logic [8:0]      used_reg, used_next;
    logic            done_reg, done_next;

    logic [3:0]      best_age_reg, best_age_next;
    logic [CW-1:0]   best_id_reg, best_id_next;
    logic [3:0]      kind_reg, kind_next;
    logic [7:0]      gr_reg, gr_next;
    logic            ev_reg, ev_next;
    logic [7:0]      granted_reg, granted_next;
    logic            evicted_reg, evicted_next;
    logic            status_reg, status_next;
    logic [7:0]      entry_reg, entry_next;

    // Table RAM ports.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Completion of the current request and its result fields.
    logic       fin;
    logic [7:0] fin_gr;
    logic       fin_ev;
    logic       fin_st;
    logic [7:0] fin_en;

    logic          idx_lt_b;
    logic [3:0]    rd_age;
    logic [7:0]    fresh;
    logic          tgt_in_table;
    logic          tgt_protected;
    logic [TW-1:0] rel_lhs;
    logic [TW-1:0] rel_rhs;

    aba_ram #(
        .WIDTH (aba_pkg::ENTRY_W),
        .DEPTH (BLOCK_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_lt_b      = (idx_reg < B_C);
    assign rd_age        = rd_data[3:0];
    assign fresh         = {kind_reg, aba_pkg::BIRTH_AGE};
    assign tgt_in_table  = ({24'd0, target_block} < 32'(BLOCK_COUNT));
    assign tgt_protected = ({24'd0, target_block} < 32'(RESERVED_BLOCKS));

    // The anchor runs ahead of the free space when anchor+1 > 16-used*16/blocks,
    // which for integers is the same as used*16 >= (16-anchor)*blocks.
    assign rel_lhs = TW'({used_reg, 4'b0000});
    assign rel_rhs = TW'(5'd16 - {1'b0, rd_age}) * TW'(BLOCK_COUNT);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        post_next     = post_reg;
        used_next     = used_reg;
        best_age_next = best_age_reg;
        best_id_next  = best_id_reg;
        kind_next     = kind_reg;
        gr_next       = gr_reg;
        ev_next       = ev_reg;

        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];

        fin    = 1'b0;
        fin_gr = '0;
        fin_ev = 1'b0;
        fin_st = 1'b0;
        fin_en = '0;

        case (state_reg)
            aba_pkg::S_CLEAR:
            begin
                wr_en = 1'b1;
                if (idx_reg == B_C - CW'(1))
                begin
                    idx_next   = '0;
                    state_next = aba_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            aba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    kind_next = file_kind;
                    case (aba_pkg::req_t'(req_type))
                        aba_pkg::REQ_ALLOC:
                        begin
                            best_age_next = aba_pkg::AGE_MAX;
                            best_id_next  = R_C;
                            pend_next     = 1'b0;
                            post_next     = 1'b0;
                            ev_next       = 1'b0;
                            if (R_C < B_C)
                            begin
                                idx_next   = R_C;
                                state_next = aba_pkg::S_SCAN;
                            end
                            else
                            begin
                                // Nothing to scan: evict with the top age,
                                // which always ages the table first.
                                idx_next   = '0;
                                state_next = aba_pkg::S_AGE;
                            end
                        end
                        aba_pkg::REQ_FREE:
                        begin
                            fin = 1'b1;
                            if (tgt_protected)
                            begin
                                fin_st = 1'b1;
                            end
                            else if (tgt_in_table)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(target_block);
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - 9'd1;
                                end
                            end
                        end
                        aba_pkg::REQ_LOAD:
                        begin
                            fin = 1'b1;
                            if (tgt_in_table)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(target_block);
                                wr_data = entry_data;
                            end
                        end
                        aba_pkg::REQ_READ:
                        begin
                            if (tgt_in_table)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(target_block);
                                state_next = aba_pkg::S_READ_WAIT;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        aba_pkg::REQ_SET_COUNT:
                        begin
                            fin       = 1'b1;
                            used_next = count_data;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            aba_pkg::S_SCAN:
            begin
                pidx_next = idx_reg[AW-1:0];
                pend_next = idx_lt_b;
                if (idx_lt_b)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (rd_data == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pidx_reg;
                        wr_data = fresh;
                        if (used_reg != aba_pkg::COUNT_MAX)
                        begin
                            used_next = used_reg + 9'd1;
                        end
                        gr_next    = 8'(pidx_reg);
                        ev_next    = 1'b0;
                        pend_next  = 1'b0;
                        state_next = aba_pkg::S_ANCHOR_RD;
                    end
                    else if (rd_age < best_age_reg)
                    begin
                        best_age_next = rd_age;
                        best_id_next  = CW'(pidx_reg);
                    end
                end
                else if (!idx_lt_b)
                begin
                    if (best_age_reg != '0)
                    begin
                        idx_next   = '0;
                        post_next  = 1'b0;
                        state_next = aba_pkg::S_AGE;
                    end
                    else
                    begin
                        state_next = aba_pkg::S_EVICT;
                    end
                end
            end

            aba_pkg::S_AGE:
            begin
                pidx_next = idx_reg[AW-1:0];
                pend_next = idx_lt_b;
                if (idx_lt_b)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (rd_age inside {[4'd1:4'd14]})
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pidx_reg;
                        wr_data = rd_data - 8'd1;
                    end
                end
                else if (!idx_lt_b)
                begin
                    if (post_reg)
                    begin
                        fin        = 1'b1;
                        fin_gr     = gr_reg;
                        fin_ev     = ev_reg;
                        state_next = aba_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = aba_pkg::S_EVICT;
                    end
                end
            end

            aba_pkg::S_EVICT:
            begin
                if (best_id_reg < B_C)
                begin
                    wr_en   = 1'b1;
                    wr_addr = best_id_reg[AW-1:0];
                    wr_data = fresh;
                end
                gr_next    = 8'(best_id_reg);
                ev_next    = 1'b1;
                state_next = aba_pkg::S_ANCHOR_RD;
            end

            aba_pkg::S_ANCHOR_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = aba_pkg::S_ANCHOR_CHK;
            end

            aba_pkg::S_ANCHOR_CHK:
            begin
                if (rel_lhs >= rel_rhs)
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    post_next  = 1'b1;
                    state_next = aba_pkg::S_AGE;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_gr     = gr_reg;
                    fin_ev     = ev_reg;
                    state_next = aba_pkg::S_IDLE;
                end
            end

            aba_pkg::S_READ_WAIT:
            begin
                fin        = 1'b1;
                fin_en     = rd_data;
                state_next = aba_pkg::S_IDLE;
            end

            default:
            begin
                state_next = aba_pkg::S_IDLE;
            end
        endcase

        done_next     = fin;
        granted_next  = fin ? fin_gr : granted_reg;
        evicted_next  = fin ? fin_ev : evicted_reg;
        status_next   = fin ? fin_st : status_reg;
        entry_next    = fin ? fin_en : entry_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aba_pkg::S_CLEAR;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            post_reg  <= 1'b0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            post_reg  <= post_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        best_age_reg <= best_age_next;
        best_id_reg  <= best_id_next;
        kind_reg     <= kind_next;
        gr_reg       <= gr_next;
        ev_reg       <= ev_next;
        granted_reg  <= granted_next;
        evicted_reg  <= evicted_next;
        status_reg   <= status_next;
        entry_reg    <= entry_next;
    end

    assign busy          = (state_reg != aba_pkg::S_IDLE);
    assign done          = done_reg;
    assign granted_block = granted_reg;
    assign evicted       = evicted_reg;
    assign status        = status_reg;
    assign entry_out     = entry_reg;
    assign used_out      = used_reg;

    // A result always lands when the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the sequencer is still busy");

    // A refused free never reports an allocation.
    a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!evicted && granted_block == 8'd0))
        else $error("refused free carries allocation fields");

    // Set used count shows done in the next cycle, with the written count.
    a_set_count: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == aba_pkg::REQ_SET_COUNT)
        |=> (done && used_out == $past(count_data)))
        else $error("set used count did not complete as expected");

    // The pipelined passes never read and write the same entry in one cycle.
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("table read and write collide on one entry");

endmodule
